FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files, included by the event fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)

`define ASSERT_NEVER(label, expr)

`endif

`endif

FILE: rtl/core/bcgd_pkg.sv
// shared types, codes and constants of the button gesture detector
package bcgd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int SLOT_W      = 3;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 16;
    localparam int CODE_W      = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    localparam logic [1:0] ST_IDLE         = 2'd0;
    localparam logic [1:0] ST_PRESSED      = 2'd1;
    localparam logic [1:0] ST_WAIT_DOUBLE  = 2'd2;
    localparam logic [1:0] ST_WAIT_RELEASE = 2'd3;

    localparam logic [CODE_W-1:0] EV_PRESS_DOWN   = 3'd0;
    localparam logic [CODE_W-1:0] EV_LONG_PRESS   = 3'd1;
    localparam logic [CODE_W-1:0] EV_RELEASE      = 3'd2;
    localparam logic [CODE_W-1:0] EV_SINGLE_CLICK = 3'd3;
    localparam logic [CODE_W-1:0] EV_DOUBLE_CLICK = 3'd4;

    localparam logic [7:0] REG_DEBOUNCE      = 8'd0;
    localparam logic [7:0] REG_LONG_PRESS    = 8'd1;
    localparam logic [7:0] REG_DOUBLE_WINDOW = 8'd2;
    localparam logic [7:0] REG_ACTIVE_LEVELS = 8'd3;

    localparam logic [THR_W-1:0]       DEBOUNCE_RST      = 16'd20;
    localparam logic [THR_W-1:0]       LONG_PRESS_RST    = 16'd1000;
    localparam logic [THR_W-1:0]       DOUBLE_WINDOW_RST = 16'd300;
    localparam logic [NUM_BUTTONS-1:0] ACTIVE_LEVELS_RST = '0;

    typedef struct packed {
        logic [1:0]        state;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        logic              press_sent;
    } slot_entry_t;

    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] button;
    } event_t;

    typedef struct packed {
        logic [THR_W-1:0] debounce;
        logic [THR_W-1:0] long_press;
        logic [THR_W-1:0] double_window;
    } thresholds_t;

endpackage

FILE: rtl/core/bcgd_slot_ram.sv
// per slot state memory, registered read, write forwarding, reset valid bits
module bcgd_slot_ram
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [bcgd_pkg::SLOT_W-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [bcgd_pkg::SLOT_W-1:0] wr_addr,
    input  bcgd_pkg::slot_entry_t       wr_data,
    output bcgd_pkg::slot_entry_t       rd_data
);
    import bcgd_pkg::*;

    slot_entry_t            mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] valid_reg;
    slot_entry_t            rdata_reg;
    logic                   rvalid_reg;
    logic                   fwd_reg;
    slot_entry_t            fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
                fwd_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // never written entries read as the reset state
    assign rd_data = fwd_reg ? fwd_data_reg : (rvalid_reg ? rdata_reg : '0);

endmodule

FILE: rtl/core/bcgd_update.sv
// per slot gesture state update and event selection
module bcgd_update
(
    input  bcgd_pkg::slot_entry_t        cur,
    input  logic                         pressed,
    input  logic [bcgd_pkg::TIME_W-1:0]  now_ms,
    input  bcgd_pkg::thresholds_t        thr,
    output bcgd_pkg::slot_entry_t        nxt,
    output logic [1:0]                   ev_count,
    output logic [bcgd_pkg::CODE_W-1:0]  ev0_code,
    output logic [bcgd_pkg::CODE_W-1:0]  ev1_code
);
    import bcgd_pkg::*;

    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] gap;
    logic              held_deb;
    logic              held_long;
    logic              gap_in_window;

    assign held          = now_ms - cur.press_stamp;
    assign gap           = now_ms - cur.release_stamp;
    assign held_deb      = held >= TIME_W'(thr.debounce);
    assign held_long     = held >= TIME_W'(thr.long_press);
    assign gap_in_window = gap <= TIME_W'(thr.double_window);

    always_comb
    begin
        nxt      = cur;
        ev_count = 2'd0;
        ev0_code = EV_PRESS_DOWN;
        ev1_code = EV_PRESS_DOWN;
        unique case (cur.state)
            ST_IDLE:
            begin
                if (pressed)
                begin
                    nxt.press_stamp = now_ms;
                    nxt.press_sent  = 1'b0;
                    nxt.state       = ST_PRESSED;
                end
            end
            ST_PRESSED:
            begin
                if (pressed)
                begin
                    if (!cur.press_sent && held_deb)
                    begin
                        nxt.press_sent = 1'b1;
                        ev_count       = 2'd1;
                        if (held_long)
                        begin
                            ev_count  = 2'd2;
                            ev1_code  = EV_LONG_PRESS;
                            nxt.state = ST_WAIT_RELEASE;
                        end
                    end
                    else if (held_long)
                    begin
                        ev_count  = 2'd1;
                        ev0_code  = EV_LONG_PRESS;
                        nxt.state = ST_WAIT_RELEASE;
                    end
                end
                else if (held_deb)
                begin
                    nxt.release_stamp = now_ms;
                    ev_count          = 2'd1;
                    ev0_code          = EV_RELEASE;
                    nxt.state         = ST_WAIT_DOUBLE;
                end
                else
                begin
                    // short press, no event
                    nxt.state = ST_IDLE;
                end
            end
            ST_WAIT_DOUBLE:
            begin
                if (pressed)
                begin
                    if (gap_in_window)
                    begin
                        ev_count  = 2'd2;
                        ev1_code  = EV_DOUBLE_CLICK;
                        nxt.state = ST_WAIT_RELEASE;
                    end
                end
                else if (!gap_in_window)
                begin
                    ev_count  = 2'd1;
                    ev0_code  = EV_SINGLE_CLICK;
                    nxt.state = ST_IDLE;
                end
            end
            ST_WAIT_RELEASE:
            begin
                if (!pressed)
                begin
                    ev_count  = 2'd1;
                    ev0_code  = EV_RELEASE;
                    nxt.state = ST_IDLE;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: rtl/core/bcgd_event_fifo.sv
// event queue, up to two words pushed and one popped per cycle
`include "assert_macros.svh"

module bcgd_event_fifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_cnt,
    input  bcgd_pkg::event_t           push0,
    input  bcgd_pkg::event_t           push1,
    input  logic                       pop,
    output logic                       not_empty,
    output bcgd_pkg::event_t           head,
    output logic [bcgd_pkg::CNT_W-1:0] count
);
    import bcgd_pkg::*;

    event_t            buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next  = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign cnt_next     = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            buf_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            buf_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign not_empty = cnt_reg != '0;
    assign head      = buf_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    `ASSERT_NEVER(a_fifo_overflow,
        (4'(cnt_reg) + 4'(push_cnt)) > (4'(FIFO_DEPTH) + 4'(pop)))
    `ASSERT_CLK(a_fifo_pop_drains,
        (pop && push_cnt == 2'd0) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
    `ASSERT_CLK(a_fifo_push_shows, (push_cnt != 2'd0) |=> not_empty)

endmodule

FILE: rtl/core/button_click_gesture_detector.sv
// top level of the button click gesture detector
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: button_index, pin_level, now_ms
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: event_button, event_code; tlast
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  a sample is read from the slot memory into a register on accept; its entry is updated and
//  written back in the cycle after accept; same slot samples back to back get the write forwarded
//  a sample is taken while the queue has room for its two words and those of the
//  sample in flight; back to back samples need an empty queue
//  the event queue holds 4 words and sets the rate when m_axis stalls
//  reset clears control state and the slot valid bits and loads the threshold reset values at once
module button_click_gesture_detector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // button_index[2:0], pin_level[3], now_ms[35:4], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // event_button[2:0], event_code[5:3], zero pad
    output logic        m_axis_tlast,   // last_of_item
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bcgd_pkg::*;

    logic                   in_accept;
    logic [SLOT_W-1:0]      in_slot;
    logic                   in_level;
    logic [TIME_W-1:0]      in_now;

    thresholds_t            thr_reg;
    logic [NUM_BUTTONS-1:0] active_levels_reg;

    logic                   s1_valid_reg;
    logic [SLOT_W-1:0]      s1_slot_reg;
    logic                   s1_level_reg;
    logic [TIME_W-1:0]      s1_now_reg;
    logic                   s1_in_range;
    logic                   s1_pressed;
    logic                   s1_do;

    slot_entry_t            cur_entry;
    slot_entry_t            nxt_entry;
    logic [1:0]             ev_count;
    logic [CODE_W-1:0]      ev0_code;
    logic [CODE_W-1:0]      ev1_code;

    logic [1:0]             push_cnt;
    event_t                 push0;
    event_t                 push1;
    logic                   pop;
    logic                   q_not_empty;
    event_t                 q_head;
    logic [CNT_W-1:0]       q_count;

    assign in_slot  = s_axis_tdata[2:0];
    assign in_level = s_axis_tdata[3];
    assign in_now   = s_axis_tdata[35:4];

    // keep room for two words from the stage in flight and two from the new sample
    assign s_axis_tready = (4'(q_count) + (s1_valid_reg ? 4'd2 : 4'd0)) <= 4'(FIFO_DEPTH - 2);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.debounce      <= DEBOUNCE_RST;
            thr_reg.long_press    <= LONG_PRESS_RST;
            thr_reg.double_window <= DOUBLE_WINDOW_RST;
            active_levels_reg     <= ACTIVE_LEVELS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:      thr_reg.debounce      <= cfg_data;
                REG_LONG_PRESS:    thr_reg.long_press    <= cfg_data;
                REG_DOUBLE_WINDOW: thr_reg.double_window <= cfg_data;
                REG_ACTIVE_LEVELS: active_levels_reg     <= cfg_data[NUM_BUTTONS-1:0];
                default:           active_levels_reg     <= active_levels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_slot_reg  <= in_slot;
            s1_level_reg <= in_level;
            s1_now_reg   <= in_now;
        end
    end

    assign s1_in_range = 32'(s1_slot_reg) < NUM_BUTTONS;
    assign s1_pressed  = s1_level_reg == active_levels_reg[s1_slot_reg];
    assign s1_do       = s1_valid_reg && s1_in_range;

    bcgd_slot_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_slot),
        .wr_en   (s1_do),
        .wr_addr (s1_slot_reg),
        .wr_data (nxt_entry),
        .rd_data (cur_entry)
    );

    bcgd_update u_update
    (
        .cur      (cur_entry),
        .pressed  (s1_pressed),
        .now_ms   (s1_now_reg),
        .thr      (thr_reg),
        .nxt      (nxt_entry),
        .ev_count (ev_count),
        .ev0_code (ev0_code),
        .ev1_code (ev1_code)
    );

    assign push_cnt     = s1_do ? ev_count : 2'd0;
    assign push0.button = s1_slot_reg;
    assign push0.code   = ev0_code;
    assign push0.last   = ev_count == 2'd1;
    assign push1.button = s1_slot_reg;
    assign push1.code   = ev1_code;
    assign push1.last   = 1'b1;

    assign pop = m_axis_tvalid && m_axis_tready;

    bcgd_event_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = {2'b00, q_head.code, q_head.button};
    assign m_axis_tlast  = q_head.last;

endmodule

FILE: verif/tb_button_click_gesture_detector.sv
// testbench of the button click gesture detector: directed table, random gestures, event checks
`timescale 1ns / 100ps

module tb_button_click_gesture_detector;
    import bcgd_pkg::*;

    localparam int          HALF_PERIOD   = 4;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          NUM_PHASES    = 8;
    localparam int          PHASE_ITEMS   = 128;
    localparam int          NUM_ROWS      = 25;
    localparam int          FIRST_CFG_ROW = 23;
    localparam int          MAX_PRINTS    = 100;
    localparam logic [7:0]  REG_UNLISTED  = 8'd4;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              level;
        logic [TIME_W-1:0] now_v;
        logic              typed;
        logic [1:0]        n_ev;
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
    } sample_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // predicted block state
    logic [1:0]             slot_st   [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_t   [NUM_BUTTONS];
    logic [TIME_W-1:0]      release_t [NUM_BUTTONS];
    logic                   sent      [NUM_BUTTONS];
    logic [THR_W-1:0]       thr_debounce;
    logic [THR_W-1:0]       thr_long;
    logic [THR_W-1:0]       thr_window;
    logic [NUM_BUTTONS-1:0] act_levels;

    event_t step_events[$];
    event_t pending_events[$];
    event_t head_event;

    // stimulus shaping
    logic [TIME_W-1:0] slot_now   [NUM_BUTTONS];
    logic              want_press [NUM_BUTTONS];
    int                gap_pct;
    int                stall_pct;
    int                stall_left;
    int                hold_left;
    int                hold_trigger;
    int                hold_seen;
    int                err_cnt;
    int                cycle_cnt;

    sample_row_t dir_rows [NUM_ROWS] = '{
        '{3'd0, 1'b1, 32'd0,         1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b0, 32'd100,       1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b0, 32'd110,       1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        // short press falls back to idle
        '{3'd0, 1'b1, 32'd115,       1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b0, 32'd200,       1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b0, 32'd220,       1'b1, 2'd1, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b1, 32'd250,       1'b1, 2'd1, EV_RELEASE,    EV_RELEASE},
        '{3'd0, 1'b0, 32'd550,       1'b1, 2'd2, EV_PRESS_DOWN, EV_DOUBLE_CLICK},
        '{3'd0, 1'b1, 32'd600,       1'b1, 2'd1, EV_RELEASE,    EV_RELEASE},
        '{3'd1, 1'b0, 32'd1000,      1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd1, 1'b0, 32'd1030,      1'b1, 2'd1, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd1, 1'b1, 32'd1040,      1'b1, 2'd1, EV_RELEASE,    EV_RELEASE},
        // second press after the window closed is ignored
        '{3'd1, 1'b0, 32'd1341,      1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd1, 1'b1, 32'd1342,      1'b1, 2'd1, EV_SINGLE_CLICK, EV_SINGLE_CLICK},
        '{3'd2, 1'b0, 32'd2000,      1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd2, 1'b0, 32'd3000,      1'b1, 2'd2, EV_PRESS_DOWN, EV_LONG_PRESS},
        '{3'd2, 1'b1, 32'd3001,      1'b1, 2'd1, EV_RELEASE,    EV_RELEASE},
        // held time across the timestamp wrap
        '{3'd7, 1'b0, 32'hFFFF_FFF0, 1'b0, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd7, 1'b0, 32'h0000_0010, 1'b0, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd7, 1'b1, 32'h0000_0020, 1'b0, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd7, 1'b1, 32'h0000_014D, 1'b0, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd3, 1'b0, 32'hFFFF_FFFF, 1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        // long press time below debounce: long press without press down
        '{3'd0, 1'b1, 32'd5000,      1'b1, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN},
        '{3'd0, 1'b1, 32'd5060,      1'b1, 2'd1, EV_LONG_PRESS, EV_LONG_PRESS}
    };

    button_click_gesture_detector dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        err_cnt = err_cnt + 1;
    endtask

    function automatic void add_event(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] code);
        event_t ev;
        ev.last   = 1'b0;
        ev.code   = code;
        ev.button = slot;
        step_events.push_back(ev);
    endfunction

    function automatic void gesture_step(input logic [SLOT_W-1:0] slot, input logic level,
                                         input logic [TIME_W-1:0] now_v);
        logic              pressed;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] gap;
        step_events.delete();
        pressed = (level == act_levels[slot]);
        held    = now_v - press_t[slot];
        gap     = now_v - release_t[slot];
        case (slot_st[slot])
            ST_IDLE:
            begin
                if (pressed)
                begin
                    press_t[slot] = now_v;
                    sent[slot]    = 1'b0;
                    slot_st[slot] = ST_PRESSED;
                end
            end
            ST_PRESSED:
            begin
                if (pressed)
                begin
                    if (!sent[slot] && held >= {16'd0, thr_debounce})
                    begin
                        add_event(slot, EV_PRESS_DOWN);
                        sent[slot] = 1'b1;
                    end
                    if (held >= {16'd0, thr_long})
                    begin
                        add_event(slot, EV_LONG_PRESS);
                        slot_st[slot] = ST_WAIT_RELEASE;
                    end
                end
                else if (held >= {16'd0, thr_debounce})
                begin
                    release_t[slot] = now_v;
                    add_event(slot, EV_RELEASE);
                    slot_st[slot] = ST_WAIT_DOUBLE;
                end
                else
                    slot_st[slot] = ST_IDLE;
            end
            ST_WAIT_DOUBLE:
            begin
                if (pressed)
                begin
                    if (gap <= {16'd0, thr_window})
                    begin
                        add_event(slot, EV_PRESS_DOWN);
                        add_event(slot, EV_DOUBLE_CLICK);
                        slot_st[slot] = ST_WAIT_RELEASE;
                    end
                end
                else if (gap > {16'd0, thr_window})
                begin
                    add_event(slot, EV_SINGLE_CLICK);
                    slot_st[slot] = ST_IDLE;
                end
            end
            default:
            begin
                if (!pressed)
                begin
                    add_event(slot, EV_RELEASE);
                    slot_st[slot] = ST_IDLE;
                end
            end
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    task automatic drive_sample(input logic [SLOT_W-1:0] slot, input logic level,
                                input logic [TIME_W-1:0] now_v, input logic typed,
                                input logic [1:0] n_ev, input logic [CODE_W-1:0] code_a,
                                input logic [CODE_W-1:0] code_b);
        event_t ev;
        @(negedge clk);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'd0, now_v, level, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        gesture_step(slot, level, now_v);
        if (typed)
        begin
            for (int k = 0; k < n_ev; k++)
            begin
                ev.button = slot;
                ev.code   = (k == 0) ? code_a : code_b;
                ev.last   = (k == n_ev - 1);
                pending_events.push_back(ev);
            end
        end
        else
        begin
            foreach (step_events[k])
                pending_events.push_back(step_events[k]);
        end
    endtask

    task automatic stop_samples();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_events_drained();
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_events_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:      thr_debounce = data;
            REG_LONG_PRESS:    thr_long     = data;
            REG_DOUBLE_WINDOW: thr_window   = data;
            REG_ACTIVE_LEVELS: act_levels   = data[NUM_BUTTONS-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] deb, input logic [15:0] lng,
                                  input logic [15:0] win, input logic [15:0] act);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_DOUBLE_WINDOW, win);
        write_reg(REG_ACTIVE_LEVELS, act);
        write_reg(8'($urandom_range(REG_UNLISTED, 255)), 16'($urandom));
    endtask

    task automatic run_rows(input int lo, input int hi);
        for (int r = lo; r <= hi; r++)
            drive_sample(dir_rows[r].slot, dir_rows[r].level, dir_rows[r].now_v,
                         dir_rows[r].typed, dir_rows[r].n_ev, dir_rows[r].code_a,
                         dir_rows[r].code_b);
        stop_samples();
    endtask

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 50));
            1:       return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 3);
            1:       return {16'd0, thr_debounce} - 1 + $urandom_range(0, 2);
            2:       return {16'd0, thr_long} - 1 + $urandom_range(0, 2);
            3:       return {16'd0, thr_window} - 1 + $urandom_range(0, 2);
            4:       return $urandom_range(0, 2000);
            5:       return $urandom_range(0, 131071);
            6:       return {17'd0, thr_long[15:1]};
            default: return 1;
        endcase
    endfunction

    task automatic run_gestures(input int n_items, input logic mid_pause);
        logic [SLOT_W-1:0] s;
        logic              lvl;
        logic [TIME_W-1:0] t;
        for (int k = 0; k < n_items; k++)
        begin
            if (mid_pause && k == n_items / 2)
            begin
                stop_samples();
                wait_events_drained();
            end
            if ($urandom_range(0, 99) < 8)
            begin
                s = 3'($urandom);
                lvl = 1'($urandom);
                t = $urandom;
                slot_now[s] = t;
            end
            else
            begin
                s = 3'($urandom_range(0, NUM_BUTTONS - 1));
                if ($urandom_range(0, 99) < 40)
                    want_press[s] = ~want_press[s];
                slot_now[s] = slot_now[s] + pick_delta();
                t = slot_now[s];
                lvl = want_press[s] ? act_levels[s] : ~act_levels[s];
            end
            drive_sample(s, lvl, t, 1'b0, 2'd0, EV_PRESS_DOWN, EV_PRESS_DOWN);
        end
        stop_samples();
    endtask

    // event receiver with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready = 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
                report("event word with none pending, tdata", m_axis_tdata, 0);
            else
            begin
                head_event = pending_events.pop_front();
                if (m_axis_tdata[2:0] != head_event.button)
                    report("event_button", m_axis_tdata[2:0], head_event.button);
                if (m_axis_tdata[5:3] != head_event.code)
                    report("event_code", m_axis_tdata[5:3], head_event.code);
                if (m_axis_tlast != head_event.last)
                    report("last_of_item", m_axis_tlast, head_event.last);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        err_cnt       = 0;
        cycle_cnt     = 0;
        stall_left    = 0;
        hold_left     = 0;
        hold_trigger  = 0;
        hold_seen     = 0;
        gap_pct       = 20;
        stall_pct     = 20;
        thr_debounce  = DEBOUNCE_RST;
        thr_long      = LONG_PRESS_RST;
        thr_window    = DOUBLE_WINDOW_RST;
        act_levels    = ACTIVE_LEVELS_RST;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            slot_st[i]    = ST_IDLE;
            press_t[i]    = '0;
            release_t[i]  = '0;
            sent[i]       = 1'b0;
            slot_now[i]   = $urandom;
            want_press[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_rows(0, FIRST_CFG_ROW - 1);
        settle();
        write_all_regs(16'd100, 16'd50, 16'd0, 16'h00A5);
        run_rows(FIRST_CFG_ROW, NUM_ROWS - 1);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_all_regs(16'd0, 16'd0, 16'd0, 16'h0000);
                1:       write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       write_all_regs(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_WINDOW_RST,
                                        16'($urandom));
                default: write_all_regs(pick_threshold(), pick_threshold(), pick_threshold(),
                                        16'($urandom));
            endcase
            case (p)
                3:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                4:
                begin
                    gap_pct      = 0;
                    stall_pct    = 15;
                    hold_trigger = hold_trigger + 1;
                end
                NUM_PHASES - 1:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                default:
                begin
                    gap_pct   = $urandom_range(5, 40);
                    stall_pct = $urandom_range(5, 40);
                end
            endcase
            run_gestures(PHASE_ITEMS, p == 5);
            settle();
        end

        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bcgd_pkg.sv
rtl/core/bcgd_slot_ram.sv
rtl/core/bcgd_update.sv
rtl/core/bcgd_event_fifo.sv
rtl/core/button_click_gesture_detector.sv
verif/tb_button_click_gesture_detector.sv
